FILE: sv/krma_pkg.sv
// ----------------------------------------------------------------------------
// krma_pkg: shared types and constants of the keyed run aggregator
// Row and group payload structs, merge rule codes, sequencer states and the
// fixed-point limits used by the merge and weighted average logic.
// ----------------------------------------------------------------------------
package krma_pkg;

  localparam int NUM_COLUMNS = 4;
  localparam int VALUE_WIDTH = 32;
  localparam int KEY_WIDTH   = 32;
  localparam int RULE_W      = 2;
  localparam int CFG_INDEX_W = 4;
  localparam int COL_W       = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int NUM_W       = 2 * VALUE_WIDTH + 2;
  localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

  typedef enum logic [RULE_W-1:0] {
    RULE_ADD = 2'd0,
    RULE_MAX = 2'd1,
    RULE_MIN = 2'd2,
    RULE_AVG = 2'd3
  } rule_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] row_key;
    value_t               value_0;
    value_t               value_1;
    value_t               value_2;
    value_t               value_3;
    logic                 end_of_rows;
  } in_row_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] group_key;
    value_t               aggregate_0;
    value_t               aggregate_1;
    value_t               aggregate_2;
    value_t               aggregate_3;
    logic                 saturated;
    logic                 last_of_run;
  } out_group_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_WAVG,
    ST_EMIT_OLD,
    ST_EMIT_END
  } agg_state_t;

  typedef enum logic [2:0] {
    WV_IDLE,
    WV_MUL_A,
    WV_MUL_B,
    WV_MAG,
    WV_CHECK,
    WV_DIV,
    WV_FIN
  } wavg_state_t;

  typedef struct packed {
    logic done;
    logic clip;
  } wavg_status_t;

endpackage

FILE: sv/krma_wavg.sv
// ----------------------------------------------------------------------------
// krma_wavg: sequential weighted average unit
// Computes (held*(total-weight) + value*weight) / total, truncated toward zero
// and saturated, with two multiply steps and a radix-2 restoring divider.
// ----------------------------------------------------------------------------
module krma_wavg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  krma_pkg::value_t        held_in,
  input  krma_pkg::value_t        value_in,
  input  krma_pkg::value_t        total_in,
  input  krma_pkg::value_t        weight_in,
  output krma_pkg::value_t        result,
  output krma_pkg::wavg_status_t  status
);

  localparam int VW = krma_pkg::VALUE_WIDTH;
  localparam int PW = krma_pkg::NUM_W;

  krma_pkg::wavg_state_t state_r, state_nxt;
  logic [krma_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  krma_pkg::value_t   a_r;
  krma_pkg::value_t   n_r;
  krma_pkg::value_t   p_r;
  logic signed [VW:0] w_r;
  logic [VW-1:0]      d_r;
  logic               tneg_r;
  logic               qneg_r;
  logic               ovf_r;
  logic signed [PW-1:0] num_r;
  logic [VW-1:0]      rem_r;
  logic [VW-1:0]      low_r;
  logic [VW-1:0]      quo_r;

  logic signed [2*VW:0]   prod_aw;
  logic signed [2*VW-1:0] prod_np;
  logic [VW+1:0]          num_hi;
  logic [VW:0]            rem2;
  logic                   ge;
  logic                   over;

  assign prod_aw = a_r * w_r;
  assign prod_np = n_r * p_r;
  assign num_hi  = num_r[PW-1:VW];
  assign rem2    = {rem_r, low_r[VW-1]};
  assign ge      = rem2 >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= krma_pkg::WV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      krma_pkg::WV_IDLE:  if (start) state_nxt = krma_pkg::WV_MUL_A;
      krma_pkg::WV_MUL_A: state_nxt = krma_pkg::WV_MUL_B;
      krma_pkg::WV_MUL_B: state_nxt = krma_pkg::WV_MAG;
      krma_pkg::WV_MAG:   state_nxt = krma_pkg::WV_CHECK;
      krma_pkg::WV_CHECK: begin
        cnt_nxt = '0;
        if (num_hi >= {2'b00, d_r}) state_nxt = krma_pkg::WV_FIN;
        else state_nxt = krma_pkg::WV_DIV;
      end
      krma_pkg::WV_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == krma_pkg::DIV_CNT_W'(VW - 1)) state_nxt = krma_pkg::WV_FIN;
      end
      krma_pkg::WV_FIN:   state_nxt = krma_pkg::WV_IDLE;
      default:            state_nxt = krma_pkg::WV_IDLE;
    endcase
  end

  always_comb begin
    if (qneg_r) over = quo_r > {1'b1, {(VW - 1){1'b0}}};
    else over = quo_r > {1'b0, {(VW - 1){1'b1}}};
    status.done = (state_r == krma_pkg::WV_FIN);
    status.clip = ovf_r || over;
    if (status.clip) result = qneg_r ? krma_pkg::VALUE_MIN : krma_pkg::VALUE_MAX;
    else if (qneg_r) result = -$signed(quo_r);
    else result = $signed(quo_r);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      krma_pkg::WV_IDLE: begin
        if (start) begin
          a_r    <= held_in;
          n_r    <= value_in;
          p_r    <= weight_in;
          w_r    <= {total_in[VW-1], total_in} - {weight_in[VW-1], weight_in};
          d_r    <= total_in[VW-1] ? $unsigned(-total_in) : $unsigned(total_in);
          tneg_r <= total_in[VW-1];
        end
      end
      krma_pkg::WV_MUL_A: begin
        num_r <= {{(PW - 2*VW - 1){prod_aw[2*VW]}}, prod_aw};
      end
      krma_pkg::WV_MUL_B: begin
        num_r <= num_r + {{(PW - 2*VW){prod_np[2*VW-1]}}, prod_np};
      end
      krma_pkg::WV_MAG: begin
        num_r  <= num_r[PW-1] ? -num_r : num_r;
        qneg_r <= num_r[PW-1] ^ tneg_r;
      end
      krma_pkg::WV_CHECK: begin
        ovf_r <= num_hi >= {2'b00, d_r};
        rem_r <= num_hi[VW-1:0];
        low_r <= num_r[VW-1:0];
        quo_r <= '0;
      end
      krma_pkg::WV_DIV: begin
        rem_r <= ge ? VW'(rem2 - {1'b0, d_r}) : rem2[VW-1:0];
        quo_r <= {quo_r[VW-2:0], ge};
        low_r <= {low_r[VW-2:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/keyed_run_multi_column_aggregator_unit.sv
// ----------------------------------------------------------------------------
// keyed_run_multi_column_aggregator_unit: group-by aggregator over sorted rows
// Merges consecutive rows of equal key column by column (add, max, min or
// weighted average) and emits each finished group with its key.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one row per beat (key, four Q16.16 values, end_of_rows flag).
//   out_* : one finished group per beat; last_of_run marks the final beat
//           caused by a row. A row causes zero, one or two beats.
//   cfg_* : merge rule per column, index = column number; always ready.
//           Write only while the block is idle.
// Steps, per row:
//   accepting a row, which also opens a group when none is open; merging: a
//   single merge step per add/max/min column and, per weighted average
//   column, a start step, two multiply steps, a sign step, an overflow check,
//   32 divider steps and a final step in the shared average unit; an
//   overflowing quotient skips the divider steps. Each beat is emitted once
//   the output register is free.
//   in_stall is high whenever the sequencer is busy with a row.
// Reset clears all rules to add and drops any open group.
// A stalled receiver holds the output register; the sequencer waits in its
// emit state, taking no new row, until the register is free for its beat.
// ----------------------------------------------------------------------------
module keyed_run_multi_column_aggregator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  krma_pkg::in_row_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output krma_pkg::out_group_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [krma_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [krma_pkg::RULE_W-1:0]         cfg_data
);

  localparam int N  = krma_pkg::NUM_COLUMNS;
  localparam int VW = krma_pkg::VALUE_WIDTH;

  krma_pkg::agg_state_t state_r, state_nxt;
  logic [krma_pkg::COL_W-1:0] col_r, col_nxt;

  krma_pkg::rule_t           rule_r [N];
  logic                      group_open_r;
  logic [krma_pkg::KEY_WIDTH-1:0] held_key_r;
  logic                      clip_r;
  krma_pkg::value_t          agg_r [N];
  krma_pkg::value_t          row_val_r [N];
  krma_pkg::value_t          prev_val_r;
  logic [krma_pkg::KEY_WIDTH-1:0] row_key_r;
  logic                      end_r;

  logic                      out_valid_r;
  krma_pkg::out_group_t      out_data_r;

  krma_pkg::value_t          in_vals [N];
  logic                      in_fire;
  logic                      out_free;
  logic                      last_col;
  krma_pkg::rule_t           rule_eff;
  logic                      avg_need;
  logic signed [VW:0]        sum;
  krma_pkg::value_t          simple_val;
  logic                      simple_clip;
  krma_pkg::value_t          step_val;
  logic                      step_clip;

  logic open_in, latch_row, col_step, wavg_start, emit_old, emit_end, out_load;

  krma_pkg::value_t      wavg_result;
  krma_pkg::wavg_status_t wavg_status;

  assign in_vals[0] = in_data.value_0;
  assign in_vals[1] = in_data.value_1;
  assign in_vals[2] = in_data.value_2;
  assign in_vals[3] = in_data.value_3;

  assign in_stall  = (state_r != krma_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign last_col  = (col_r == krma_pkg::COL_W'(N - 1));

  always_comb begin
    rule_eff = rule_r[col_r];
    if (rule_eff == krma_pkg::RULE_AVG && col_r == '0) rule_eff = krma_pkg::RULE_ADD;
  end

  assign avg_need = (rule_eff == krma_pkg::RULE_AVG) && (agg_r[N-1] != '0);
  assign sum      = {agg_r[0][VW-1], agg_r[0]} + {row_val_r[0][VW-1], row_val_r[0]};

  always_comb begin
    simple_val  = agg_r[0];
    simple_clip = 1'b0;
    case (rule_eff)
      krma_pkg::RULE_ADD: begin
        if (sum[VW] != sum[VW-1]) begin
          simple_clip = 1'b1;
          simple_val  = sum[VW] ? krma_pkg::VALUE_MIN : krma_pkg::VALUE_MAX;
        end else begin
          simple_val = sum[VW-1:0];
        end
      end
      krma_pkg::RULE_MAX: simple_val = (agg_r[0] > row_val_r[0]) ? agg_r[0] : row_val_r[0];
      krma_pkg::RULE_MIN: simple_val = (agg_r[0] > row_val_r[0]) ? row_val_r[0] : agg_r[0];
      default:            simple_val = agg_r[0];
    endcase
  end

  assign step_val  = (state_r == krma_pkg::ST_WAVG) ? wavg_result : simple_val;
  assign step_clip = (state_r == krma_pkg::ST_WAVG) ? wavg_status.clip : simple_clip;

  krma_wavg u_wavg (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (wavg_start),
    .held_in   (agg_r[0]),
    .value_in  (row_val_r[0]),
    .total_in  (agg_r[N-1]),
    .weight_in (prev_val_r),
    .result    (wavg_result),
    .status    (wavg_status)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      krma_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!group_open_r)
            state_nxt = in_data.end_of_rows ? krma_pkg::ST_EMIT_END : krma_pkg::ST_IDLE;
          else if (in_data.row_key == held_key_r) state_nxt = krma_pkg::ST_MERGE;
          else state_nxt = krma_pkg::ST_EMIT_OLD;
        end
      end
      krma_pkg::ST_MERGE: begin
        if (avg_need) state_nxt = krma_pkg::ST_WAVG;
        else if (last_col) state_nxt = end_r ? krma_pkg::ST_EMIT_END : krma_pkg::ST_IDLE;
      end
      krma_pkg::ST_WAVG: begin
        if (wavg_status.done) begin
          if (last_col) state_nxt = end_r ? krma_pkg::ST_EMIT_END : krma_pkg::ST_IDLE;
          else state_nxt = krma_pkg::ST_MERGE;
        end
      end
      krma_pkg::ST_EMIT_OLD: begin
        if (out_free) state_nxt = end_r ? krma_pkg::ST_EMIT_END : krma_pkg::ST_IDLE;
      end
      krma_pkg::ST_EMIT_END: begin
        if (out_free) state_nxt = krma_pkg::ST_IDLE;
      end
      default: state_nxt = krma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    open_in    = (state_r == krma_pkg::ST_IDLE) && in_fire && !group_open_r;
    latch_row  = (state_r == krma_pkg::ST_IDLE) && in_fire && group_open_r;
    wavg_start = (state_r == krma_pkg::ST_MERGE) && avg_need;
    col_step   = ((state_r == krma_pkg::ST_MERGE) && !avg_need) ||
                 ((state_r == krma_pkg::ST_WAVG) && wavg_status.done);
    emit_old   = (state_r == krma_pkg::ST_EMIT_OLD) && out_free;
    emit_end   = (state_r == krma_pkg::ST_EMIT_END) && out_free;
    out_load   = emit_old || emit_end;
    col_nxt    = col_r;
    if (latch_row) col_nxt = '0;
    else if (col_step) col_nxt = last_col ? '0 : col_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= krma_pkg::ST_IDLE;
      col_r        <= '0;
      group_open_r <= 1'b0;
      held_key_r   <= '0;
      clip_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < N; i++) rule_r[i] <= krma_pkg::RULE_ADD;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      if (cfg_valid && cfg_ready && cfg_index < krma_pkg::CFG_INDEX_W'(N))
        rule_r[cfg_index[krma_pkg::COL_W-1:0]] <= krma_pkg::rule_t'(cfg_data);
      if (open_in) begin
        group_open_r <= 1'b1;
        held_key_r   <= in_data.row_key;
        clip_r       <= 1'b0;
      end else if (emit_old) begin
        group_open_r <= 1'b1;
        held_key_r   <= row_key_r;
        clip_r       <= 1'b0;
      end else if (col_step) begin
        clip_r <= clip_r | step_clip;
      end
      if (emit_end) group_open_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) end_r <= in_data.end_of_rows;
    if (latch_row) begin
      row_key_r <= in_data.row_key;
      for (int i = 0; i < N; i++) row_val_r[i] <= in_vals[i];
    end
    if (open_in) begin
      for (int i = 0; i < N; i++) agg_r[i] <= in_vals[i];
    end else if (emit_old) begin
      for (int i = 0; i < N; i++) agg_r[i] <= row_val_r[i];
    end else if (col_step) begin
      for (int i = 0; i < N - 1; i++) begin
        agg_r[i]     <= agg_r[i+1];
        row_val_r[i] <= row_val_r[i+1];
      end
      agg_r[N-1]     <= step_val;
      row_val_r[N-1] <= row_val_r[0];
      prev_val_r     <= row_val_r[0];
    end
    if (out_load) begin
      out_data_r.group_key   <= held_key_r;
      out_data_r.aggregate_0 <= agg_r[0];
      out_data_r.aggregate_1 <= agg_r[1];
      out_data_r.aggregate_2 <= agg_r[2];
      out_data_r.aggregate_3 <= agg_r[3];
      out_data_r.saturated   <= clip_r;
      out_data_r.last_of_run <= emit_end || !end_r;
    end
  end

  a_done_in_wavg: assert property (@(posedge clk) disable iff (!rst_n)
    wavg_status.done |-> (state_r == krma_pkg::ST_WAVG))
    else $error("average unit finished outside its wait state");

  a_merge_needs_group: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == krma_pkg::ST_MERGE || state_r == krma_pkg::ST_WAVG) |-> group_open_r)
    else $error("merge running without an open group");

  a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
    emit_end |=> (!group_open_r && out_valid && out_data.last_of_run))
    else $error("final beat did not close the group");

  a_old_beat_not_last_when_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_old && end_r) |=> (out_valid && !out_data.last_of_run &&
                             state_r == krma_pkg::ST_EMIT_END))
    else $error("closed group beat before flush marked last");

endmodule
